FILE: rtl/kehr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kehr_pkg
// shared types and constants of the key event queue and boot report builder
// ----------------------------------------------------------------------------
package kehr_pkg;

   localparam int DefaultQueueDepth = 16;
   localparam int NumSlots          = 6;
   localparam int CountOutWidth     = 5;
   localparam int CmdFifoDepth      = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_QUEUED  = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_APPLIED = 2'd3
   } status_type;

   typedef enum logic {
      FRONT_IDLE = 1'b0,
      FRONT_READ = 1'b1
   } front_state_type;

   // one classified item on its way from the front to the back
   typedef struct packed {
      status_type                 status;
      logic [7:0]                 key_code;
      logic                       key_pressed;
      logic [CountOutWidth-1:0]   queued_count;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

FILE: rtl/kehr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kehr_front
// accepts items, runs the event ring queue and classifies each item
// ----------------------------------------------------------------------------
module kehr_front
   import kehr_pkg::*;
#(
   parameter int QUEUE_DEPTH = DefaultQueueDepth
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_op,
   input  logic [7:0]      req_key_code,
   input  logic            req_key_pressed,
   input  fifo_status_type fifo_status,
   output logic            cmd_push,
   output cmd_type         cmd_data
);

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   front_state_type      state_ff, state_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic [8:0]           event_store_ff [QUEUE_DEPTH];
   logic [8:0]           rd_data_ff;
   logic                 accept;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 do_write;
   logic                 do_read;
   logic [31:0]          count_wide;

   function automatic logic [PtrWidth-1:0] ptr_next(input logic [PtrWidth-1:0] p);
      if (p == PtrWidth'(QUEUE_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + 1'b1;
      end
   endfunction

   assign req_ready   = (state_ff == FRONT_IDLE) && !fifo_status.full;
   assign accept      = req_valid && req_ready;
   assign queue_full  = (count_ff == CntWidth'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign do_write    = accept && (req_op == OP_PUSH) && !queue_full;
   assign do_read     = accept && (req_op == OP_POP) && !queue_empty;

   // next state
   always_comb begin
      state_in  = state_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (do_write) begin
               wr_ptr_in = ptr_next(wr_ptr_ff);
               count_in  = count_ff + 1'b1;
            end
            if (do_read) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
               count_in  = count_ff - 1'b1;
               state_in  = FRONT_READ;
            end
         end
         FRONT_READ: begin
            state_in = FRONT_IDLE;
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      count_wide            = 32'(count_in);
      cmd_push              = 1'b0;
      cmd_data.status       = ST_QUEUED;
      cmd_data.key_code     = rd_data_ff[7:0];
      cmd_data.key_pressed  = rd_data_ff[8];
      cmd_data.queued_count = count_wide[CountOutWidth-1:0];
      case (state_ff)
         FRONT_IDLE: begin
            cmd_push = accept && !do_read;
            if (req_op == OP_PUSH) begin
               cmd_data.status = queue_full ? ST_FULL : ST_QUEUED;
            end else begin
               cmd_data.status = ST_EMPTY;
            end
         end
         FRONT_READ: begin
            cmd_push        = 1'b1;
            cmd_data.status = ST_APPLIED;
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FRONT_IDLE;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         event_store_ff[wr_ptr_ff] <= {req_key_pressed, req_key_code};
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         rd_data_ff <= event_store_ff[rd_ptr_ff];
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(QUEUE_DEPTH))
      else $error("event count beyond queue depth");
   a_read_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FRONT_READ) |-> !fifo_status.full)
      else $error("no command slot for a popped event");
   a_pop_reads: assert property (@(posedge clock) disable iff (reset)
      do_read |=> (state_ff == FRONT_READ) && cmd_push)
      else $error("pop did not issue its command after the read");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == CntWidth'(QUEUE_DEPTH)) ||
      (rd_ptr_ff != wr_ptr_ff))
      else $error("pointers meet while queue is partly filled");
`endif

endmodule

FILE: rtl/kehr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kehr_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module kehr_cmd_fifo
   import kehr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         push_data,
   input  logic            pop,
   output cmd_type         head_data,
   output fifo_status_type status
);

   localparam int PtrWidth = $clog2(CmdFifoDepth);
   localparam int CntWidth = $clog2(CmdFifoDepth + 1);

   cmd_type             entry_ff [CmdFifoDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CntWidth'(CmdFifoDepth));
   assign status.empty = (count_ff == '0);
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PtrWidth'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PtrWidth'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("push into full command queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("pop from empty command queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command count did not follow a push");
`endif

endmodule

FILE: rtl/kehr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kehr_back
// applies popped events to the boot report and holds the result register
// ----------------------------------------------------------------------------
module kehr_back
   import kehr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  fifo_status_type          fifo_status,
   input  cmd_type                  head_data,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [7:0]               rsp_modifier_bits,
   output logic [7:0]               rsp_slot_a,
   output logic [7:0]               rsp_slot_b,
   output logic [7:0]               rsp_slot_c,
   output logic [7:0]               rsp_slot_d,
   output logic [7:0]               rsp_slot_e,
   output logic [7:0]               rsp_slot_f,
   output logic [CountOutWidth-1:0] rsp_queued_count
);

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff;
   logic [CountOutWidth-1:0] count_ff;
   logic [7:0]               modifier_ff, modifier_in;
   logic [7:0]               slot_ff [NumSlots];
   logic [7:0]               slot_in [NumSlots];
   logic [7:0]               match_code;
   logic                     found;
   logic [7:0]               mod_mask;

   assign cmd_pop = !fifo_status.empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // report update for an applied event
   always_comb begin
      modifier_in = modifier_ff;
      for (int i = 0; i < NumSlots; i++) begin
         slot_in[i] = slot_ff[i];
      end
      match_code = head_data.key_pressed ? 8'h00 : head_data.key_code;
      found      = 1'b0;
      mod_mask   = 8'(1 << head_data.key_code[2:0]);
      if (cmd_pop && (head_data.status == ST_APPLIED)) begin
         if (head_data.key_code inside {[8'h04:8'hA4]}) begin
            // first empty slot on press, first matching slot on release
            for (int i = 0; i < NumSlots; i++) begin
               if (!found && (slot_ff[i] == match_code)) begin
                  slot_in[i] = head_data.key_pressed ? head_data.key_code : 8'h00;
                  found      = 1'b1;
               end
            end
         end else if (head_data.key_code inside {[8'hE0:8'hE7]}) begin
            modifier_in = head_data.key_pressed ? (modifier_ff | mod_mask)
                                                : (modifier_ff & ~mod_mask);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         modifier_ff  <= '0;
         for (int i = 0; i < NumSlots; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         modifier_ff  <= modifier_in;
         for (int i = 0; i < NumSlots; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         status_ff <= head_data.status;
         count_ff  <= head_data.queued_count;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_queued_count  = count_ff;
   assign rsp_modifier_bits = modifier_ff;
   assign rsp_slot_a        = slot_ff[0];
   assign rsp_slot_b        = slot_ff[1];
   assign rsp_slot_c        = slot_ff[2];
   assign rsp_slot_d        = slot_ff[3];
   assign rsp_slot_e        = slot_ff[4];
   assign rsp_slot_f        = slot_ff[5];

`ifndef SYNTHESIS
   a_report_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd_pop |=> (modifier_ff == $past(modifier_ff)))
      else $error("modifier byte changed without an event");
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rsp_valid_ff)
      else $error("command taken without a result");
   a_only_applied: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && (head_data.status != ST_APPLIED)) |=>
      (modifier_ff == $past(modifier_ff)) && (slot_ff[0] == $past(slot_ff[0])))
      else $error("report changed on an item that applies nothing");
`endif

endmodule

FILE: rtl/key_event_queue_to_hid_report_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_queue_to_hid_report_top
// ring queue of key events feeding a six-key boot keyboard report
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  op, key_code, key_pressed
// rsp       out        rsp_valid / rsp_ready  status, modifier, six slots, count
//
// pushes and empty pops reach the command queue in the cycle they are accepted;
// a stored event first passes the registered memory read and the FRONT_READ state
// the back applies one command a cycle unless rsp stalls; its result is registered
// synchronous reset clears pointers, queue counts, report and all valid flags;
// event memory, result status and count are not reset; meaningless until written
// a stalled rsp side fills the two-entry command queue, then req_ready drops
// ----------------------------------------------------------------------------
module key_event_queue_to_hid_report_top
   import kehr_pkg::*;
#(
   parameter int QUEUE_DEPTH = DefaultQueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic [7:0]               req_key_code,
   input  logic                     req_key_pressed,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [7:0]               rsp_modifier_bits,
   output logic [7:0]               rsp_slot_a,
   output logic [7:0]               rsp_slot_b,
   output logic [7:0]               rsp_slot_c,
   output logic [7:0]               rsp_slot_d,
   output logic [7:0]               rsp_slot_e,
   output logic [7:0]               rsp_slot_f,
   output logic [CountOutWidth-1:0] rsp_queued_count
);

   // front to queue
   logic            cmd_push;
   cmd_type         cmd_in;
   // queue to back
   logic            cmd_pop;
   cmd_type         cmd_head;
   fifo_status_type fifo_status;

   // event ring queue and item classification
   kehr_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key_code    (req_key_code),
      .req_key_pressed (req_key_pressed),
      .fifo_status     (fifo_status),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_in)
   );

   // decouples front from back
   kehr_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .head_data (cmd_head),
      .status    (fifo_status)
   );

   // report update and result register
   kehr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .fifo_status       (fifo_status),
      .head_data         (cmd_head),
      .cmd_pop           (cmd_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_modifier_bits (rsp_modifier_bits),
      .rsp_slot_a        (rsp_slot_a),
      .rsp_slot_b        (rsp_slot_b),
      .rsp_slot_c        (rsp_slot_c),
      .rsp_slot_d        (rsp_slot_d),
      .rsp_slot_e        (rsp_slot_e),
      .rsp_slot_f        (rsp_slot_f),
      .rsp_queued_count  (rsp_queued_count)
   );

endmodule
